// ----- src/baro_pressure_temp_compensation_assert.svh -----
// assertion macros shared by the checker of the pressure/temperature block
// no dependencies; each macro expands to one concurrent assertion
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BPTC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bptc assertion failed");

// next-cycle implication, disabled during reset
`define BPTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bptc assertion failed");

`endif

// ----- src/bptc_pkg.sv -----
// shared types and constants of the pressure/temperature compensation block
// no dependencies
package bptc_pkg;

  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int PRESS_W   = 27;
  localparam int TEMP_W    = 12;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SENS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TCS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TCO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TREF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TSENS = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] tcs;
    logic [COEF_W-1:0] tco;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tsens;
  } cfg_t;

endpackage

// ----- src/bptc_pipe.sv -----
// ten-stage compensation datapath with per-stage valid and ready
// depends on bptc_pkg for widths and the calibration struct
module bptc_pipe (
  input  logic                             clk,
  input  logic                             rst,
  input  bptc_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bptc_pkg::RAW_W-1:0]       raw_pressure,
  input  logic [bptc_pkg::RAW_W-1:0]       raw_temperature,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bptc_pkg::PRESS_W-1:0] pressure_pa,
  output logic signed [bptc_pkg::TEMP_W-1:0]  temperature_celsius
);
  import bptc_pkg::*;

  localparam int NSTG = 10;
  // ceil(2^25 / 100), exact floor divide for values below 2^18
  localparam logic [18:0] RCP100 = 19'd335545;

  logic [NSTG:1] v;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !v[NSTG] || out_ready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int i = 2; i <= NSTG; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[NSTG];

  // stage registers
  logic [RAW_W-1:0]   s1_d1, s2_d1, s3_d1, s4_d1, s5_d1, s6_d1;
  logic signed [24:0] s1_dt;
  logic signed [41:0] s2_pt, s2_po, s2_ps;
  logic signed [17:0] s3_q;
  logic signed [39:0] s3_off1, s3_sens1, s4_off1, s4_sens1, s5_off1, s5_sens1;
  logic [35:0]        s4_sq, s4_esq;
  logic               s4_low, s4_vlow, s4_tneg;
  logic [36:0]        s4_tp;
  logic [39:0]        s5_off2, s5_sens2;
  logic signed [TEMP_W-1:0] s5_t, s6_t, s7_t, s8_t, s9_t, s10_t;
  logic signed [39:0] s6_off, s6_sens, s7_off, s8_off;
  logic [43:0]        s7_plo;
  logic signed [44:0] s7_phi;
  logic signed [64:0] s8_prod;
  logic signed [45:0] s9_num;
  logic signed [PRESS_W-1:0] s10_press;

  // stage 1: dT
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d1 <= raw_pressure;
      s1_dt <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.tref, 8'h00});
    end
  end

  // stage 2: dT products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_d1 <= s1_d1;
      s2_pt <= s1_dt * $signed({1'b0, cfg.tsens});
      s2_po <= s1_dt * $signed({1'b0, cfg.tco});
      s2_ps <= s1_dt * $signed({1'b0, cfg.tcs});
    end
  end

  // stage 3: centidegree delta, first-order offset and sensitivity
  logic signed [41:0] pt_adj, po_sh, ps_sh;
  always_comb begin
    pt_adj = s2_pt + (s2_pt[41] ? 42'sd8388607 : 42'sd0);
    po_sh  = s2_po >>> 7;
    ps_sh  = s2_ps >>> 8;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_d1    <= s2_d1;
      s3_q     <= pt_adj[40:23];
      s3_off1  <= $signed({8'h00, cfg.off, 16'h0000}) + $signed(po_sh[39:0]);
      s3_sens1 <= $signed({9'h000, cfg.sens, 15'h0000}) + $signed(ps_sh[39:0]);
    end
  end

  // stage 4: squares, range flags, reciprocal product for degrees
  logic signed [35:0] q_sq;
  logic signed [18:0] e_w, t_w;
  logic signed [37:0] e_sq;
  logic [17:0]        t_abs;
  always_comb begin
    q_sq  = s3_q * s3_q;
    e_w   = {s3_q[17], s3_q} + 19'sd3500;
    e_sq  = e_w * e_w;
    t_w   = {s3_q[17], s3_q} + 19'sd2050;
    t_abs = t_w[18] ? 18'(-t_w) : t_w[17:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_d1    <= s3_d1;
      s4_off1  <= s3_off1;
      s4_sens1 <= s3_sens1;
      s4_sq    <= q_sq;
      s4_esq   <= e_sq[35:0];
      s4_low   <= s3_q[17];
      s4_vlow  <= s3_q < -18'sd3500;
      s4_tneg  <= t_w[18];
      s4_tp    <= t_abs * RCP100;
    end
  end

  // stage 5: second-order terms, degrees
  logic [39:0] sq5, e7, e11;
  logic [11:0] t_mag;
  always_comb begin
    sq5   = {4'h0, s4_sq} + {2'b00, s4_sq, 2'b00};
    e7    = {1'b0, s4_esq, 3'b000} - {4'h0, s4_esq};
    e11   = {1'b0, s4_esq, 3'b000} + {3'b000, s4_esq, 1'b0} + {4'h0, s4_esq};
    t_mag = s4_tp[36:25];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_d1    <= s4_d1;
      s5_off1  <= s4_off1;
      s5_sens1 <= s4_sens1;
      s5_t     <= s4_tneg ? $signed(-t_mag) : $signed(t_mag);
      if (s4_low) begin
        s5_off2  <= (sq5 >> 1) + (s4_vlow ? e7 : 40'd0);
        s5_sens2 <= (sq5 >> 2) + (s4_vlow ? (e11 >> 1) : 40'd0);
      end else begin
        s5_off2  <= '0;
        s5_sens2 <= '0;
      end
    end
  end

  // stage 6: final offset and sensitivity
  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_d1   <= s5_d1;
      s6_t    <= s5_t;
      s6_off  <= s5_off1 - $signed(s5_off2);
      s6_sens <= s5_sens1 - $signed(s5_sens2);
    end
  end

  // stage 7: D1 times SENS as two partial products
  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_t   <= s6_t;
      s7_off <= s6_off;
      s7_plo <= s6_d1 * s6_sens[19:0];
      s7_phi <= $signed({1'b0, s6_d1}) * $signed(s6_sens[39:20]);
    end
  end

  // stage 8: combine partial products
  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_t    <= s7_t;
      s8_off  <= s7_off;
      s8_prod <= $signed({s7_phi, 20'h00000}) + $signed({21'h000000, s7_plo});
    end
  end

  // stage 9: scale and remove offset
  logic signed [64:0] pr_sh;
  assign pr_sh = s8_prod >>> 21;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_t   <= s8_t;
      s9_num <= $signed(pr_sh[45:0]) - $signed({{6{s8_off[39]}}, s8_off});
    end
  end

  // stage 10: divide by 2^15 toward zero
  logic signed [45:0] num_adj;
  assign num_adj = s9_num + (s9_num[45] ? 46'sd32767 : 46'sd0);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_t     <= s9_t;
      s10_press <= num_adj[41:15];
    end
  end

  assign pressure_pa         = s10_press;
  assign temperature_celsius = s10_t;

endmodule

// ----- src/baro_pressure_temp_compensation.sv -----
// Throughput: one sample pair per cycle while the master side takes results; the ten-stage datapath pipeline sets it.
// Each stage has its own valid bit, so bubbles fill while the output is stalled.
// Reset (rst, synchronous): empties the pipeline and clears all six calibration
// registers to zero.
// top level: calibration registers and stream packing; depends on bptc_pkg, bptc_pipe
module baro_pressure_temp_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [47:0]                        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [26:0] pressure_pa, [38:27] temperature_celsius, [39] zero
  output logic [39:0]                        m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bptc_pkg::COEF_W-1:0]        cfg_data
);
  import bptc_pkg::*;

  cfg_t cfg;
  logic signed [PRESS_W-1:0] press;
  logic signed [TEMP_W-1:0]  tdeg;

  assign cfg_ready = 1'b1;

  // indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENS:  cfg.sens  <= cfg_data;
        REG_OFF:   cfg.off   <= cfg_data;
        REG_TCS:   cfg.tcs   <= cfg_data;
        REG_TCO:   cfg.tco   <= cfg_data;
        REG_TREF:  cfg.tref  <= cfg_data;
        REG_TSENS: cfg.tsens <= cfg_data;
        default: ;
      endcase
    end
  end

  bptc_pipe u_pipe (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .in_valid            (s_axis_tvalid),
    .in_ready            (s_axis_tready),
    .raw_pressure        (s_axis_tdata[23:0]),
    .raw_temperature     (s_axis_tdata[47:24]),
    .out_valid           (m_axis_tvalid),
    .out_ready           (m_axis_tready),
    .pressure_pa         (press),
    .temperature_celsius (tdeg)
  );

  assign m_axis_tdata = {1'b0, tdeg, press};

endmodule

// ----- src/bptc_checker.sv -----
// port-level checks of the compensation block, bound to the top level
// depends on baro_pressure_temp_compensation_assert.svh
`include "baro_pressure_temp_compensation_assert.svh"

module bptc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // a stalled result stays
  `BPTC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `BPTC_ASSERT_NEXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // an empty output stage means every stage can take a request
  `BPTC_ASSERT_IMPL(a_ready_free, clk, rst, !m_axis_tvalid, s_axis_tready)
  // whole degrees always land in the sensor range
  `BPTC_ASSERT_IMPL(a_temp_range, clk, rst, m_axis_tvalid, ($signed(m_axis_tdata[38:27]) >= -12'sd1300) && ($signed(m_axis_tdata[38:27]) <= 12'sd1340))

endmodule

bind baro_pressure_temp_compensation bptc_checker u_chk (.*);
